// ===== design/ut2dos_pkg.sv =====
// Month table and leap rule for the Unix time to DOS date converter.
package ut2dos_pkg;

  // Day offset of each month within its year.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] v;
    begin
      case (m)
        4'd0:    v = 9'd0;
        4'd1:    v = 9'd31;
        4'd2:    v = leap ? 9'd60  : 9'd59;
        4'd3:    v = leap ? 9'd91  : 9'd90;
        4'd4:    v = leap ? 9'd121 : 9'd120;
        4'd5:    v = leap ? 9'd152 : 9'd151;
        4'd6:    v = leap ? 9'd182 : 9'd181;
        4'd7:    v = leap ? 9'd213 : 9'd212;
        4'd8:    v = leap ? 9'd244 : 9'd243;
        4'd9:    v = leap ? 9'd274 : 9'd273;
        4'd10:   v = leap ? 9'd305 : 9'd304;
        4'd11:   v = leap ? 9'd335 : 9'd334;
        default: v = 9'd0;
      endcase
      return v;
    end
  endfunction

  // Gregorian leap rule over the years 1970 to 2106.
  function automatic logic is_leap(input logic [11:0] y);
    begin
      return (y[1:0] == 2'b00) && (y != 12'd2100);
    end
  endfunction

endpackage

// ===== design/unix_time_to_dos_datetime.sv =====
// Top level of the Unix time to calendar and DOS date/time converter.
// Usage: pulse start with unix_seconds whenever busy is low (busy is always low, so one
// transaction may enter every cycle). Each result appears with done high for one cycle,
// after the four divide stages for days and time of day, the three calendar stages and
// the output register. The receiver cannot stall the block.
module unix_time_to_dos_datetime
  import ut2dos_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] unix_seconds,
  output logic        done,
  output logic [11:0] cal_year,
  output logic [3:0]  cal_month,
  output logic [4:0]  cal_day,
  output logic [4:0]  cal_hour,
  output logic [5:0]  cal_minute,
  output logic [5:0]  cal_second,
  output logic [31:0] packed_dos_time
);

  logic        sp_valid;
  logic [15:0] sp_days;
  logic [4:0]  sp_hour;
  logic [5:0]  sp_min, sp_sec;

  assign busy = 1'b0;

  ut2dos_split u_split (
    .clk(clk), .rst(rst), .in_valid(start), .secs(unix_seconds),
    .out_valid(sp_valid), .days(sp_days), .hour(sp_hour),
    .minute(sp_min), .second(sp_sec)
  );

  // Time of day waits alongside the calendar stages.
  logic [4:0] h_d [3];
  logic [5:0] m_d [3];
  logic [5:0] s_d [3];
  always_ff @(posedge clk) begin
    h_d[0] <= sp_hour; m_d[0] <= sp_min; s_d[0] <= sp_sec;
    for (int i = 1; i < 3; i++) begin
      h_d[i] <= h_d[i-1]; m_d[i] <= m_d[i-1]; s_d[i] <= s_d[i-1];
    end
  end

  logic        dt_valid;
  logic [11:0] dt_year;
  logic [3:0]  dt_month;
  logic [4:0]  dt_day;
  ut2dos_date u_date (
    .clk(clk), .rst(rst), .in_valid(sp_valid), .days(sp_days),
    .out_valid(dt_valid), .year(dt_year), .month(dt_month), .day(dt_day)
  );

  // Output register with the packed DOS word.
  logic [11:0] yoff;
  assign yoff = dt_year - 12'd1980;
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dt_valid;
    end
    cal_year   <= dt_year;
    cal_month  <= dt_month;
    cal_day    <= dt_day;
    cal_hour   <= h_d[2];
    cal_minute <= m_d[2];
    cal_second <= s_d[2];
    packed_dos_time <= {yoff[6:0], dt_month, dt_day, h_d[2], m_d[2], s_d[2][5:1]};
  end

endmodule

// ===== design/ut2dos_split.sv =====
// Divides seconds into days and second of day, then into hour, minute and second.
module ut2dos_split
  import ut2dos_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] secs,
  output logic        out_valid,
  output logic [15:0] days,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  // floor(x/675) for x < 2^25 via multiply by floor(2^36/675) with one correction.
  localparam logic [35:0] Recip = 36'd101806632;

  // Stage 1: days by reciprocal multiply; 2^-7 taken first since 86400 = 128*675.
  logic [24:0] s1_hi;
  logic [6:0]  s1_lo;
  logic        s1_valid;
  logic [15:0] s1_q;
  logic [35:0] s1_prod;
  logic [60:0] in_mul;

  always_comb in_mul = {36'd0, secs[31:7]} * {25'd0, Recip};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_hi <= secs[31:7];
    s1_lo <= secs[6:0];
    s1_q  <= in_mul[51:36];
  end

  // The estimate may be one low; correct quotient and remainder.
  logic [24:0] s1_rem;
  logic [24:0] s1_rc;
  logic [15:0] s1_qc;
  always_comb begin
    s1_prod = {20'd0, s1_q} * 36'd675;
    s1_rem  = s1_hi - s1_prod[24:0];
    s1_qc   = (s1_rem >= 25'd675) ? s1_q + 16'd1 : s1_q;
    s1_rc   = (s1_rem >= 25'd675) ? s1_rem - 25'd675 : s1_rem;
  end

  // Stage 2: day count and second of day.
  logic        s2_valid;
  logic [15:0] s2_days;
  logic [16:0] s2_sod;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_days <= s1_qc;
    s2_sod  <= {s1_rc[9:0], s1_lo};
  end

  // Stage 3: hour and second of hour; 3600 = 16*225, so x>>4 over 225.
  logic [12:0] s2_x;
  logic [25:0] s2_hm;
  logic [4:0]  s2_h;
  logic [12:0] s2_hd;
  logic [11:0] s2_soh;
  always_comb begin
    s2_x   = s2_sod[16:4];
    s2_hm  = {13'd0, s2_x} * 26'd4661;
    s2_h   = s2_hm[24:20];
    s2_hd  = s2_x - {8'd0, s2_h} * 13'd225;
    s2_soh = {s2_hd[7:0], s2_sod[3:0]};
  end
  logic       s3_valid;
  logic [15:0] s3_days;
  logic [4:0] s3_hour;
  logic [11:0] s3_soh;
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_days <= s2_days;
    s3_hour <= s2_h;
    s3_soh  <= s2_soh;
  end

  // Stage 4: minute and second; divide by 60 with multiply by 4370 >> 18.
  logic [24:0] s3_mm;
  logic [5:0]  s3_m;
  logic [11:0] s3_ms;
  always_comb begin
    s3_mm = {13'd0, s3_soh} * 25'd4370;
    s3_m  = s3_mm[23:18];
    s3_ms = s3_soh - {6'd0, s3_m} * 12'd60;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s3_valid;
    end
    days   <= s3_days;
    hour   <= s3_hour;
    minute <= s3_m;
    second <= s3_ms[5:0];
  end

endmodule

// ===== design/ut2dos_date.sv =====
// Turns a day count since 1970 into year, month and day of month.
module ut2dos_date
  import ut2dos_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [15:0] days,
  output logic        out_valid,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day
);

  // Stage 1: guess the year as days*717/2^18, 717 being 2^18/365.25 rounded low; keep the day count.
  logic [33:0] g_mul;
  logic        s1_valid;
  logic [15:0] s1_days;
  logic [7:0]  s1_yo;
  always_comb g_mul = {18'd0, days} * 34'd717;
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_days <= days;
    s1_yo   <= g_mul[25:18];
  end

  // Days before Jan 1 of 1970+yo, with the missing leap day in 2100.
  function automatic logic [15:0] year_start(input logic [7:0] yo);
    logic [15:0] b;
    logic [7:0]  l;
    begin
      l = (yo + 8'd1) >> 2;
      if (yo > 8'd130) l = l - 8'd1;
      b = 16'(16'(yo) * 16'd365) + 16'(l);
      return b;
    end
  endfunction

  // Stage 2: correct the guess by one year either way.
  logic [15:0] s1_b0, s1_b1;
  logic [7:0]  s1_y;
  logic [15:0] s1_doy;
  always_comb begin
    s1_b0 = year_start(s1_yo);
    s1_b1 = year_start(s1_yo + 8'd1);
    if (s1_days < s1_b0) begin
      s1_y   = s1_yo - 8'd1;
      s1_doy = s1_days - year_start(s1_yo - 8'd1);
    end else if (s1_days >= s1_b1) begin
      s1_y   = s1_yo + 8'd1;
      s1_doy = s1_days - s1_b1;
    end else begin
      s1_y   = s1_yo;
      s1_doy = s1_days - s1_b0;
    end
  end
  logic        s2_valid;
  logic [11:0] s2_year;
  logic [8:0]  s2_doy;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_year <= 12'd1970 + 12'(s1_y);
    s2_doy  <= s1_doy[8:0];
  end

  // Stage 3: month search over the table in parallel compares.
  logic       lp;
  logic [3:0] m;
  always_comb begin
    lp = is_leap(s2_year);
    m  = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (s2_doy >= month_start(lp, 4'(i))) m = 4'(i);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s2_valid;
    end
    year  <= s2_year;
    month <= m + 4'd1;
    day   <= 5'(s2_doy - month_start(lp, m) + 9'd1);
  end

endmodule
